FILE: src/sha512_pkg.sv
// SHA-512 / SHA-384 shared types, constants and round functions.
// No dependencies.
package sha512_pkg;

  typedef struct packed {
    logic [63:0] msg_word;
    logic [3:0]  byte_count;
    logic        last_chunk;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        word_last;
    logic        length_error;
  } out_item_t;

  // front to back command: one buffer word to write, optional compress/finish
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  widx;
    logic        wr;
    logic        comp;
    logic        fin;
    logic        err;
  } cmd_t;

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
    64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
    64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
    64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
    64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
    64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
    64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
    64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
    64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
    64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
    64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
    64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
    64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
    64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
  };

  localparam logic [63:0] IV_512 [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };
  localparam logic [63:0] IV_384 [8] = '{
    64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17, 64'h152FECD8F70E5939,
    64'h67332667FFC00B31, 64'h8EB44A8768581511, 64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] LEN_POS  = 7'd112;

  function automatic logic [63:0] ror(input logic [63:0] x, input int n);
    ror = (x >> n) | (x << (64 - n));
  endfunction

endpackage

FILE: src/sha512_front.sv
// Front end: packs message bytes, tracks length, emits padding commands.
// Depends on sha512_pkg.
module sha512_front import sha512_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     clear,
  input  in_item_t in_item,
  input  logic     in_valid,
  output logic     in_stall,
  output cmd_t     cmd,
  output logic     cmd_valid,
  input  logic     cmd_stall
);
  typedef enum logic [1:0] {S_IDLE, S_DATA, S_PAD, S_LEN} state_t;

  state_t      state;
  logic [6:0]  fill;
  logic [63:0] total;
  logic        ovf;
  logic [63:0] acc;
  in_item_t    cur;
  logic [3:0]  n;
  logic [3:0]  nb;
  logic        drop;
  logic [7:0]  sum;
  logic        crossed;
  logic [63:0] msg_m;
  logic [63:0] rest;
  logic [63:0] merged;
  logic [63:0] acc_next;
  logic [63:0] mask;
  logic [6:0]  fill_next;
  logic [64:0] tsum;

  assign in_stall = (state != S_IDLE);
  assign n = (cur.byte_count > 4'd8) ? 4'd8 : cur.byte_count;
  assign tsum = {1'b0, total} + {61'd0, n};
  assign drop = tsum[64];
  assign nb = drop ? 4'd0 : n;
  assign sum = {1'b0, fill} + {4'd0, nb};
  assign crossed = (sum[7:3] != {1'b0, fill[6:3]});
  assign msg_m = cur.msg_word & ~(64'hFFFF_FFFF_FFFF_FFFF >> {nb, 3'b000});
  assign rest = msg_m << {4'd8 - {1'b0, fill[2:0]}, 3'b000};
  assign mask = (fill[2:0] == 3'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> {fill[2:0], 3'b000});
  assign merged = (acc & mask) | ((msg_m >> {fill[2:0], 3'b000}) & ~mask);
  assign acc_next = (sum[2:0] == 3'd0) ? 64'd0 : (crossed ? rest : merged);

  always_comb begin
    cmd = '0;
    cmd_valid = 1'b0;
    fill_next = fill;
    cmd.err = ovf;
    case (state)
      S_DATA: begin
        cmd.widx = fill[6:3];
        cmd.data = merged;
        cmd.wr = 1'b1;
        cmd.comp = crossed && (fill[6:3] == 4'hF);
        cmd_valid = crossed;
        fill_next = sum[6:0];
      end
      S_PAD: begin
        cmd.widx = fill[6:3];
        cmd.data = acc;
        cmd.wr = 1'b1;
        cmd.comp = (fill[6:3] == 4'hF);
        cmd_valid = 1'b1;
        fill_next = {fill[6:3] + 4'd1, 3'b000};
      end
      S_LEN: begin
        cmd.widx = fill[3] ? 4'hF : 4'hE;
        cmd.data = fill[3] ? {total[60:0], 3'b000} : {61'd0, total[63:61]};
        cmd.wr = 1'b1;
        cmd.comp = fill[3];
        cmd.fin = fill[3];
        cmd_valid = 1'b1;
        fill_next = fill[3] ? 7'd0 : 7'd120;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state <= S_IDLE;
      fill <= '0;
      total <= '0;
      ovf <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          cur <= in_item;
          state <= S_DATA;
        end
        S_DATA: if (!cmd_stall || !cmd_valid) begin
          if (drop) ovf <= 1'b1; else total <= tsum[63:0];
          if (!cur.last_chunk) begin
            acc <= acc_next;
            fill <= fill_next;
            state <= S_IDLE;
          end else begin
            // put the 0x80 byte into the word being built
            acc <= acc_next | ({PAD_BYTE, 56'd0} >> {sum[2:0], 3'b000});
            fill <= {sum[6:3], 3'b000};
            state <= S_PAD;
          end
        end
        S_PAD: if (!cmd_stall) begin
          acc <= '0;
          fill <= fill_next;
          if (fill_next == LEN_POS) state <= S_LEN;
        end
        S_LEN: if (!cmd_stall) begin
          fill <= fill_next;
          if (fill[3]) begin
            state <= S_IDLE;
            total <= '0;
            ovf <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: src/sha512_queue.sv
// Two-entry command queue between front end and compression engine.
// Depends on sha512_pkg.
module sha512_queue import sha512_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  cmd_t wr_cmd,
  input  logic wr_valid,
  output logic wr_stall,
  output cmd_t rd_cmd,
  output logic rd_valid,
  input  logic rd_stall
);
  cmd_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign wr_stall = (cnt == 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_cmd = mem[rp];
  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_cmd;
    if (rst || clear) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: src/sha512_core.sv
// Back end: block buffer, 80-round compression, chain value, digest output.
// Depends on sha512_pkg.
module sha512_core import sha512_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      clear,
  input  logic      mode,
  input  cmd_t      cmd,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_stall
);
  typedef enum logic [1:0] {S_IDLE, S_ROUND, S_ADD, S_OUT} state_t;

  state_t      state;
  logic [63:0] buf_w [16];
  logic [63:0] cv [8];
  logic [63:0] v [8];
  logic [6:0]  rnd;
  logic [2:0]  oidx;
  logic        fin;
  logic        err;
  logic [63:0] x, s0, s1, wn, t1, t2, a2, a15;

  assign cmd_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_item.digest_word = cv[oidx];
  assign out_item.word_last = mode ? (oidx == 3'd5) : (oidx == 3'd7);
  assign out_item.length_error = err;

  always_comb begin
    a2 = buf_w[rnd[3:0] - 4'd2];
    a15 = buf_w[rnd[3:0] - 4'd15];
    s1 = ror(a2, 19) ^ ror(a2, 61) ^ (a2 >> 6);
    s0 = ror(a15, 1) ^ ror(a15, 8) ^ (a15 >> 7);
    wn = s1 + buf_w[rnd[3:0] - 4'd7] + s0 + buf_w[rnd[3:0]];
    x = (rnd < 7'd16) ? buf_w[rnd[3:0]] : wn;
    t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
       + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + ROUND_K[rnd] + x;
    t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
       + ((v[0] & v[1]) | (v[2] & (v[0] ^ v[1])));
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (cmd_valid && cmd.wr) buf_w[cmd.widx] <= cmd.data;
      S_ROUND: buf_w[rnd[3:0]] <= x;
      default: ;
    endcase
    if (rst || clear) begin
      state <= S_IDLE;
      for (int i = 0; i < 8; i++) cv[i] <= (clear && mode) ? IV_384[i] : IV_512[i];
    end else begin
      case (state)
        S_IDLE: if (cmd_valid && cmd.comp) begin
          for (int i = 0; i < 8; i++) v[i] <= cv[i];
          rnd <= '0;
          fin <= cmd.fin;
          err <= cmd.err;
          state <= S_ROUND;
        end
        S_ROUND: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) cv[i] <= cv[i] + v[i];
          oidx <= '0;
          state <= fin ? S_OUT : S_IDLE;
        end
        S_OUT: if (!out_stall) begin
          oidx <= oidx + 3'd1;
          if (out_item.word_last) begin
            for (int i = 0; i < 8; i++) cv[i] <= mode ? IV_384[i] : IV_512[i];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: src/sha512_sha384_hash_top.sv
// channel | valid   | stall     | payload
// in      | valid   | stall     | in_data (msg_word, byte_count, last_chunk)
// out     | out_vld | out_stall | out_data (digest_word, word_last, length_error)
// cfg     | cfg_we  | -         | cfg_data[0] = digest_mode
// The front end takes each word through its idle and data states; each full block
// holds the round engine for its rounds (one round per cycle) and the chain-value add.
// The last word adds padding words, one or two compressions, then 6 or 8 digest words.
// Reset (rst, synchronous) and a mode write load the IV and clear the message.
// Depends on sha512_pkg, sha512_front, sha512_queue, sha512_core.
module sha512_sha384_hash_top import sha512_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      valid,
  output logic      stall,
  input  in_item_t  in_data,
  output logic      out_vld,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_data
);
  logic mode;
  cmd_t f_cmd, q_cmd;
  logic f_valid, f_stall, q_valid, q_stall;

  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b0;
    else if (cfg_we) mode <= cfg_data;
  end

  logic clear;
  logic clear_mode;
  assign clear = cfg_we;
  assign clear_mode = cfg_data;

  logic core_mode;
  assign core_mode = cfg_we ? clear_mode : mode;

  sha512_front u_front (
    .clk, .rst, .clear, .in_item(in_data), .in_valid(valid), .in_stall(stall),
    .cmd(f_cmd), .cmd_valid(f_valid), .cmd_stall(f_stall));

  sha512_queue u_queue (
    .clk, .rst, .clear, .wr_cmd(f_cmd), .wr_valid(f_valid), .wr_stall(f_stall),
    .rd_cmd(q_cmd), .rd_valid(q_valid), .rd_stall(q_stall));

  sha512_core u_core (
    .clk, .rst, .clear, .mode(core_mode), .cmd(q_cmd), .cmd_valid(q_valid),
    .cmd_stall(q_stall), .out_item(out_data), .out_valid(out_vld), .out_stall(out_stall));

  a_out_hold: assert property (@(posedge clk) disable iff (rst || cfg_we)
    out_vld && out_stall |=> out_vld && $stable(out_data))
    else $error("digest item changed while stalled");
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !(q_valid && !q_stall))
    else $error("command taken while digest pending");
endmodule
